/* hdl/prgs_pkg.sv */
// Shared types and constants for the PageRank Gauss-Seidel solver.
// No dependencies; imported by the divider and the top level.
package prgs_pkg;

  // Default parameter values for the top level
  localparam int MAX_NODES_DEF = 64;
  localparam int RANK_BITS_DEF = 32;

  // Fixed field widths
  localparam int CNT_W   = 7;   // node count, degree and node loop counters
  localparam int NODE_W  = 6;   // node fields on the ports
  localparam int DAMP_W  = 16;  // damping, Q0.16
  localparam int THR_W   = 32;  // threshold, Q0.32
  localparam int ITER_W  = 8;   // sweep limit and sweep count
  localparam int CFG_W   = 32;  // config write data
  localparam int CFGI_W  = 2;   // config register index
  localparam int DEN_W   = CNT_W + DAMP_W;  // widest divisor: degree << 16
  localparam int ACC_W   = 64;  // squared change, Q0.64

  // Register reset values
  localparam logic [CNT_W-1:0]  NODE_COUNT_RST = 7'd64;
  localparam logic [DAMP_W-1:0] DAMPING_RST    = 16'd55706;
  localparam logic [THR_W-1:0]  THRESHOLD_RST  = 32'd429497;
  localparam logic [ITER_W-1:0] ITER_LIMIT_RST = 8'd200;

  // Configuration register indexes
  typedef enum logic [CFGI_W-1:0] {
    REG_NODE_COUNT     = 2'd0,
    REG_DAMPING        = 2'd1,
    REG_STOP_THRESHOLD = 2'd2,
    REG_ITER_LIMIT     = 2'd3
  } reg_index_t;

  // Divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* hdl/prgs_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prgs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/prgs_div.sv */
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on prgs_pkg (div_stat_t, DEN_W).
module prgs_div #(
  parameter int DW = 48
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DW-1:0]           dividend,
  input  logic [prgs_pkg::DEN_W-1:0] divisor,
  output logic [DW-1:0]           quotient,
  output prgs_pkg::div_stat_t     stat
);
  import prgs_pkg::*;

  localparam int CW = $clog2(DW);

  logic [DEN_W-1:0] dvsr;
  logic [DEN_W-1:0] rem;
  logic [CW-1:0]    step;
  logic [DEN_W:0]   trial;

  // shift in the next dividend bit
  assign trial = {rem, quotient[DW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start && !stat.busy) begin
        stat.busy <= 1'b1;
        quotient  <= dividend;
        dvsr      <= divisor;
        rem       <= '0;
        step      <= '0;
      end else if (stat.busy) begin
        if (trial >= {1'b0, dvsr}) begin
          rem      <= DEN_W'(trial - {1'b0, dvsr});
          quotient <= {quotient[DW-2:0], 1'b1};
        end else begin
          rem      <= trial[DEN_W-1:0];
          quotient <= {quotient[DW-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == CW'(DW - 1)) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hdl/pagerank_gauss_seidel_solver.sv */
// PageRank Gauss-Seidel solver: edge loader, degree pass, sweep sequencer.
// Depends on prgs_pkg, prgs_ram (link, degree, rank stores) and prgs_div.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  edge in  | in_valid / in_stall  | source_node, target_node, final_edge
//  rank out | out_valid / out_stall| node_index, rank_value, sweeps_done,
//           |                      | converged, last_rank
//  config   | cfg_write            | cfg_index, cfg_data
//
// An edge inside the graph takes a read-modify-write of the link row in
// S_LOAD; an edge outside it is not stored. The final edge starts the solve:
// degree count (a row read and an accumulate per node), degree write, the
// setup divides, fill, then per sweep and node a row read, a scan of the
// columns and a divide per in-link and for a self-link. Each result is read,
// loaded and held until not stalled. Reset clears the link row valid bits at once; no sweep.
module pagerank_gauss_seidel_solver #(
  parameter int MAX_NODES = prgs_pkg::MAX_NODES_DEF,
  parameter int RANK_BITS = prgs_pkg::RANK_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [prgs_pkg::NODE_W-1:0]   source_node,
  input  logic [prgs_pkg::NODE_W-1:0]   target_node,
  input  logic                          final_edge,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [prgs_pkg::NODE_W-1:0]   node_index,
  output logic [31:0]                   rank_value,
  output logic [prgs_pkg::ITER_W-1:0]   sweeps_done,
  output logic                          converged,
  output logic                          last_rank,
  input  logic                          cfg_write,
  input  logic [prgs_pkg::CFGI_W-1:0]   cfg_index,
  input  logic [prgs_pkg::CFG_W-1:0]    cfg_data
);
  import prgs_pkg::*;

  localparam int ROWS = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int NB   = $clog2(ROWS);
  localparam int DW   = RANK_BITS + 16;
  localparam int MA   = (RANK_BITS > 32) ? RANK_BITS : 32;
  localparam int PW   = MA + 32;
  localparam int NUMW = RANK_BITS + CNT_W;
  localparam logic [RANK_BITS-1:0] MAXR = {RANK_BITS{1'b1}};

  typedef enum logic [4:0] {
    S_IDLE, S_LOAD, S_DEG_RD, S_DEG_ACC, S_DEG_WR,
    S_INIT_GO, S_INIT_W, S_BASE_GO, S_BASE_W, S_THR_M, S_THR_SAVE, S_FILL,
    S_SWEEP, S_ROW_RD, S_ROW_GET, S_SCAN, S_TERM_M, S_TERM_GO, S_TERM_W,
    S_SELF_CHK, S_SELF_RD, S_SELF_M, S_SELF_GO, S_SELF_W, S_DIFF, S_SQ_M,
    S_ACC, S_CHECK, S_OUT_RD, S_OUT_LOAD, S_OUT_WAIT
  } state_t;

  // config registers
  logic [CNT_W-1:0]  node_count;
  logic [DAMP_W-1:0] damping;
  logic [THR_W-1:0]  stop_threshold;
  logic [ITER_W-1:0] iteration_limit;

  // sequencer registers
  state_t                state;
  logic [CNT_W-1:0]      i_cnt, j_cnt;
  logic [ROWS-1:0]       row_valid, dangle, col_bits;
  logic [CNT_W-1:0]      cnt [ROWS];
  logic [NODE_W-1:0]     es, et;
  logic                  efin;
  logic [CNT_W-1:0]      deg_q;
  logic [RANK_BITS-1:0]  old_q, x_val, init_val;
  logic [NUMW-1:0]       num;
  logic [RANK_BITS:0]    base;
  logic [ACC_W-1:0]      thr2, acc;
  logic [31:0]           dq;
  logic [ITER_W-1:0]     sweep;
  logic                  conv;
  logic [PW-1:0]         prod;

  // combinational helpers
  logic [CNT_W-1:0]      n_eff;
  logic [ITER_W-1:0]     lim;
  logic                  last_i, in_range, link_here;
  logic [MA-1:0]         mul_a;
  logic [31:0]           mul_b;
  logic                  div_start;
  logic [DW-1:0]         div_dividend, div_q;
  logic [DEN_W-1:0]      div_divisor;
  div_stat_t             div_st;
  logic [RANK_BITS-1:0]  room, abs_d;
  logic [ACC_W:0]        acc_sum;

  // RAM ports
  logic                  link_we, deg_we, rank_we;
  logic [NB-1:0]         link_waddr, link_raddr, deg_waddr, deg_raddr;
  logic [NB-1:0]         rank_waddr, rank_raddr;
  logic [ROWS-1:0]       link_wdata, link_rd;
  logic [CNT_W-1:0]      deg_wdata, deg_rd;
  logic [RANK_BITS-1:0]  rank_wdata, rank_rd;

  function automatic logic [31:0] to_q32(input logic [RANK_BITS-1:0] v);
    logic [RANK_BITS+31:0] w;
    w = {v, 32'b0};
    return w[RANK_BITS+31:RANK_BITS];
  endfunction

  // effective node count and sweep limit
  assign n_eff = (node_count == '0) ? CNT_W'(1) :
                 (node_count > CNT_W'(ROWS)) ? CNT_W'(ROWS) : node_count;
  assign lim      = (iteration_limit == '0) ? ITER_W'(1) : iteration_limit;
  assign last_i   = (i_cnt == n_eff - 1'b1);
  assign in_range = ({1'b0, source_node} < n_eff) && ({1'b0, target_node} < n_eff);
  assign link_here = (col_bits[j_cnt[NB-1:0]] | dangle[j_cnt[NB-1:0]]) &&
                     (j_cnt != i_cnt);
  assign in_stall = (state != S_IDLE);

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      node_count      <= NODE_COUNT_RST;
      damping         <= DAMPING_RST;
      stop_threshold  <= THRESHOLD_RST;
      iteration_limit <= ITER_LIMIT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_NODE_COUNT:     node_count      <= cfg_data[CNT_W-1:0];
        REG_DAMPING:        damping         <= cfg_data[DAMP_W-1:0];
        REG_STOP_THRESHOLD: stop_threshold  <= cfg_data[THR_W-1:0];
        REG_ITER_LIMIT:     iteration_limit <= cfg_data[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // RAM address and write selection
  always_comb begin
    link_we    = (state == S_LOAD);
    link_waddr = et[NB-1:0];
    link_wdata = (row_valid[et[NB-1:0]] ? link_rd : '0) | (ROWS'(1) << es[NB-1:0]);
    link_raddr = (state == S_IDLE) ? target_node[NB-1:0] : i_cnt[NB-1:0];

    deg_we    = (state == S_DEG_WR);
    deg_waddr = j_cnt[NB-1:0];
    deg_wdata = (cnt[0] == '0) ? n_eff : cnt[0];
    deg_raddr = (state == S_SELF_CHK) ? i_cnt[NB-1:0] : j_cnt[NB-1:0];

    rank_we    = (state == S_FILL) || (state == S_DIFF);
    rank_waddr = (state == S_FILL) ? j_cnt[NB-1:0] : i_cnt[NB-1:0];
    rank_wdata = (state == S_FILL) ? init_val : x_val;
    rank_raddr = (state == S_SCAN) ? j_cnt[NB-1:0] : i_cnt[NB-1:0];
  end

  // shared multiplier operands
  always_comb begin
    case (state)
      S_THR_M:  begin mul_a = MA'(stop_threshold);   mul_b = stop_threshold; end
      S_TERM_M: begin mul_a = MA'(rank_rd);          mul_b = 32'(damping);   end
      S_SELF_M: begin mul_a = MA'(num[RANK_BITS-1:0]); mul_b = 32'(damping); end
      S_SQ_M:   begin mul_a = MA'(dq);               mul_b = dq;             end
      default:  begin mul_a = '0;                    mul_b = '0;             end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PW'(mul_a) * PW'(mul_b);
  end

  // shared divider requests
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = DEN_W'(n_eff);
    case (state)
      S_INIT_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(1) << RANK_BITS;
      end
      S_BASE_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(17'h10000 - {1'b0, damping}) << (RANK_BITS - 16);
      end
      S_TERM_GO: begin
        div_start    = 1'b1;
        div_dividend = DW'(prod[DW-1:16]);
        div_divisor  = DEN_W'(deg_q);
      end
      S_SELF_GO: begin
        div_start    = 1'b1;
        div_dividend = prod[DW-1:0];
        div_divisor  = {deg_q, 16'b0} - DEN_W'(damping);
      end
      default: ;
    endcase
  end

  // update arithmetic
  assign room    = MAXR - num[RANK_BITS-1:0];
  assign abs_d   = (x_val > old_q) ? (x_val - old_q) : (old_q - x_val);
  assign acc_sum = {1'b0, acc} + {1'b0, prod[ACC_W-1:0]};

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      row_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            es   <= source_node;
            et   <= target_node;
            efin <= final_edge;
            i_cnt <= '0;
            for (int k = 0; k < ROWS; k++) cnt[k] <= '0;
            if (in_range) state <= S_LOAD;
            else if (final_edge) state <= S_DEG_RD;
          end
        end
        S_LOAD: begin
          row_valid[et[NB-1:0]] <= 1'b1;
          state <= efin ? S_DEG_RD : S_IDLE;
        end
        S_DEG_RD: state <= S_DEG_ACC;
        S_DEG_ACC: begin
          // column popcount: one lane per source node
          for (int k = 0; k < ROWS; k++) begin
            if ((CNT_W'(k) < n_eff) && row_valid[i_cnt[NB-1:0]]) begin
              cnt[k] <= cnt[k] + CNT_W'(link_rd[k]);
            end
          end
          i_cnt <= i_cnt + 1'b1;
          j_cnt <= '0;
          state <= last_i ? S_DEG_WR : S_DEG_RD;
        end
        S_DEG_WR: begin
          dangle[j_cnt[NB-1:0]] <= (cnt[0] == '0);
          for (int k = 0; k < ROWS - 1; k++) cnt[k] <= cnt[k+1];
          cnt[ROWS-1] <= '0;
          j_cnt <= j_cnt + 1'b1;
          if (j_cnt == n_eff - 1'b1) state <= S_INIT_GO;
        end
        S_INIT_GO: state <= S_INIT_W;
        S_INIT_W: begin
          if (div_st.done) begin
            init_val <= (div_q > DW'(MAXR)) ? MAXR : div_q[RANK_BITS-1:0];
            state    <= S_BASE_GO;
          end
        end
        S_BASE_GO: state <= S_BASE_W;
        S_BASE_W: begin
          if (div_st.done) begin
            base  <= div_q[RANK_BITS:0];
            state <= S_THR_M;
          end
        end
        S_THR_M: state <= S_THR_SAVE;
        S_THR_SAVE: begin
          thr2  <= prod[ACC_W-1:0];
          sweep <= '0;
          j_cnt <= '0;
          state <= S_FILL;
        end
        S_FILL: begin
          j_cnt <= j_cnt + 1'b1;
          if (j_cnt == n_eff - 1'b1) state <= S_SWEEP;
        end
        S_SWEEP: begin
          sweep <= sweep + 1'b1;
          acc   <= '0;
          i_cnt <= '0;
          state <= S_ROW_RD;
        end
        S_ROW_RD: state <= S_ROW_GET;
        S_ROW_GET: begin
          col_bits <= row_valid[i_cnt[NB-1:0]] ? link_rd : '0;
          num      <= NUMW'(base);
          j_cnt    <= '0;
          state    <= S_SCAN;
        end
        // walk in-links of node i
        S_SCAN: begin
          if (j_cnt == n_eff) state <= S_SELF_CHK;
          else if (link_here) state <= S_TERM_M;
          else j_cnt <= j_cnt + 1'b1;
        end
        S_TERM_M: begin
          deg_q <= deg_rd;
          state <= S_TERM_GO;
        end
        S_TERM_GO: state <= S_TERM_W;
        S_TERM_W: begin
          if (div_st.done) begin
            num   <= num + NUMW'(div_q[RANK_BITS-1:0]);
            j_cnt <= j_cnt + 1'b1;
            state <= S_SCAN;
          end
        end
        S_SELF_CHK: begin
          if (num > NUMW'(MAXR)) num <= NUMW'(MAXR);
          state <= S_SELF_RD;
        end
        S_SELF_RD: begin
          deg_q <= deg_rd;
          old_q <= rank_rd;
          x_val <= num[RANK_BITS-1:0];
          if (col_bits[i_cnt[NB-1:0]] | dangle[i_cnt[NB-1:0]]) state <= S_SELF_M;
          else state <= S_DIFF;
        end
        S_SELF_M: state <= S_SELF_GO;
        S_SELF_GO: state <= S_SELF_W;
        S_SELF_W: begin
          if (div_st.done) begin
            x_val <= (div_q > DW'(room)) ? MAXR :
                     num[RANK_BITS-1:0] + div_q[RANK_BITS-1:0];
            state <= S_DIFF;
          end
        end
        S_DIFF: begin
          dq    <= to_q32(abs_d);
          state <= S_SQ_M;
        end
        S_SQ_M: state <= S_ACC;
        S_ACC: begin
          acc   <= acc_sum[ACC_W] ? {ACC_W{1'b1}} : acc_sum[ACC_W-1:0];
          i_cnt <= i_cnt + 1'b1;
          state <= last_i ? S_CHECK : S_ROW_RD;
        end
        S_CHECK: begin
          conv  <= (acc <= thr2);
          i_cnt <= '0;
          if ((acc <= thr2) || (sweep >= lim)) state <= S_OUT_RD;
          else state <= S_SWEEP;
        end
        // emit ranks
        S_OUT_RD: state <= S_OUT_LOAD;
        S_OUT_LOAD: begin
          node_index  <= i_cnt[NODE_W-1:0];
          rank_value  <= to_q32(rank_rd);
          sweeps_done <= sweep;
          converged   <= conv;
          last_rank   <= last_i;
          out_valid   <= 1'b1;
          state       <= S_OUT_WAIT;
        end
        S_OUT_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_rank) begin
              row_valid <= '0;
              state     <= S_IDLE;
            end else begin
              i_cnt <= i_cnt + 1'b1;
              state <= S_OUT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  prgs_ram #(.WIDTH(ROWS), .DEPTH(ROWS)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(link_raddr), .rdata(link_rd)
  );

  prgs_ram #(.WIDTH(CNT_W), .DEPTH(ROWS)) u_deg_ram (
    .clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rd)
  );

  prgs_ram #(.WIDTH(RANK_BITS), .DEPTH(ROWS)) u_rank_ram (
    .clk(clk), .we(rank_we), .waddr(rank_waddr), .wdata(rank_wdata),
    .raddr(rank_raddr), .rdata(rank_rd)
  );

  prgs_div #(.DW(DW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .quotient(div_q), .stat(div_st)
  );

  // checks
  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("edge input open while a rank beat is pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_rank) |=> !in_stall)
    else $error("solver not ready after the last rank beat");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_st.busy)
    else $error("divide requested while divider busy");

endmodule

/* tb/pagerank_gauss_seidel_solver_tb.sv */
// Testbench for pagerank_gauss_seidel_solver: edge beats in, rank beats out,
// predicted by a fixed-point Gauss-Seidel model kept here. Depends on prgs_pkg.
module pagerank_gauss_seidel_solver_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import prgs_pkg::*;

  typedef struct packed {
    logic [NODE_W-1:0] src;
    logic [NODE_W-1:0] dst;
    logic              fin;
  } edge_beat_t;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic [31:0]       rank;
    logic [ITER_W-1:0] sweeps;
    logic              conv;
    logic              last;
  } rank_beat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [NODE_W-1:0] source_node = '0;
  logic [NODE_W-1:0] target_node = '0;
  logic final_edge = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [NODE_W-1:0] node_index;
  logic [31:0] rank_value;
  logic [ITER_W-1:0] sweeps_done;
  logic converged;
  logic last_rank;
  logic cfg_write = 1'b0;
  logic [CFGI_W-1:0] cfg_index = REG_NODE_COUNT;
  logic [CFG_W-1:0] cfg_data = '0;

  pagerank_gauss_seidel_solver dut (.*);

  always #5 clk = ~clk;

  // Mirror of the registers and the link matrix
  logic [CNT_W-1:0]  m_nodes = NODE_COUNT_RST;
  logic [DAMP_W-1:0] m_damp  = DAMPING_RST;
  logic [THR_W-1:0]  m_thr   = THRESHOLD_RST;
  logic [ITER_W-1:0] m_limit = ITER_LIMIT_RST;
  logic [63:0] link_rows [64];

  edge_beat_t edge_queue[$];
  rank_beat_t rank_queue[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int edges_sent = 0;
  int ranks_seen = 0;
  int solves = 0;

  // Accept one edge; on a final edge run the solve and queue its ranks
  task automatic load_edge(edge_beat_t e);
    int n, deg;
    longint unsigned maxr, d, base, num, x, q, diff, sq, acc, thr2, den;
    longint unsigned rk [64];
    int unsigned outdeg [64];
    int sweeps, lim;
    bit conv;
    rank_beat_t r;
    maxr = 64'hFFFF_FFFF;
    n = (m_nodes == 0) ? 1 : (m_nodes > 64 ? 64 : int'(m_nodes));
    if (e.src < n && e.dst < n) link_rows[e.src][e.dst] = 1'b1;
    if (!e.fin) return;
    solves++;
    for (int i = 0; i < n; i++) begin
      deg = 0;
      for (int j = 0; j < n; j++) deg += link_rows[i][j];
      if (deg == 0) begin
        for (int j = 0; j < n; j++) link_rows[i][j] = 1'b1;
        deg = n;
      end
      outdeg[i] = deg;
    end
    for (int i = 0; i < n; i++) rk[i] = 64'h1_0000_0000 / n;
    for (int i = 0; i < n; i++) if (rk[i] > maxr) rk[i] = maxr;
    d = m_damp;
    base = ((65536 - d) << 16) / n;
    lim = (m_limit == 0) ? 1 : int'(m_limit);
    thr2 = longint'(m_thr) * longint'(m_thr);
    sweeps = 0;
    forever begin
      acc = 0;
      sweeps++;
      for (int i = 0; i < n; i++) begin
        num = base;
        for (int j = 0; j < n; j++)
          if (j != i && link_rows[j][i])
            num += (rk[j] * d) / (longint'(outdeg[j]) << 16);
        if (num > maxr) num = maxr;
        x = num;
        if (link_rows[i][i]) begin
          den = (longint'(outdeg[i]) << 16) - d;
          q = (num * d) / den;
          x = (q > maxr - num) ? maxr : num + q;
        end
        diff = (x > rk[i]) ? x - rk[i] : rk[i] - x;
        sq = diff * diff;
        acc = (acc > 64'hFFFF_FFFF_FFFF_FFFF - sq) ? 64'hFFFF_FFFF_FFFF_FFFF : acc + sq;
        rk[i] = x;
      end
      conv = (acc <= thr2);
      if (conv || sweeps >= lim) break;
    end
    for (int i = 0; i < n; i++) begin
      r.node = NODE_W'(i);
      r.rank = rk[i][31:0];
      r.sweeps = ITER_W'(sweeps);
      r.conv = conv;
      r.last = (i == n - 1);
      rank_queue.push_back(r);
    end
    for (int i = 0; i < 64; i++) link_rows[i] = '0;
  endtask

  // Edge driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (edge_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        edge_beat_t e;
        e = edge_queue.pop_front();
        source_node <= e.src;
        target_node <= e.dst;
        final_edge <= e.fin;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Monitor: predict on accepted edges, check accepted ranks
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      load_edge('{src: source_node, dst: target_node, fin: final_edge});
      edges_sent++;
    end
    if (!rst && out_valid && !out_stall) begin
      rank_beat_t got, want;
      got = '{node: node_index, rank: rank_value, sweeps: sweeps_done,
              conv: converged, last: last_rank};
      ranks_seen++;
      if (rank_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected rank beat: %p", got);
      end else begin
        want = rank_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("rank mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_NODE_COUNT:     m_nodes = val[CNT_W-1:0];
      REG_DAMPING:        m_damp = val[DAMP_W-1:0];
      REG_STOP_THRESHOLD: m_thr = val[THR_W-1:0];
      default:            m_limit = val[ITER_W-1:0];
    endcase
  endtask

  task automatic set_all(int nodes, int damp, logic [31:0] thr, int lim);
    write_reg(REG_NODE_COUNT, nodes);
    write_reg(REG_DAMPING, damp);
    write_reg(REG_STOP_THRESHOLD, thr);
    write_reg(REG_ITER_LIMIT, lim);
  endtask

  function automatic void add_edge(int s, int t, bit f);
    edge_queue.push_back('{src: NODE_W'(s), dst: NODE_W'(t), fin: f});
  endfunction

  // Ring over all 64 nodes, closed by a final beat
  function automatic void add_ring();
    for (int i = 0; i < 64; i++) add_edge(i, (i + 1) % 64, i == 63);
  endfunction

  // Wait until every edge went in and every rank came out, settle, then set the stall mode
  task automatic drain(int mode);
    while (edge_queue.size() > 0 || in_valid || rank_queue.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 29; recv_stall_pct = 29; end
    endcase
  endtask

  initial begin
    int phase, n, cnt, lim, pick;
    logic [31:0] thr;
    for (int i = 0; i < 64; i++) link_rows[i] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset defaults on a full ring
    add_ring();
    drain(1);
    // Node count zero, no damping, zero threshold, zero sweep limit
    set_all(0, 0, 32'd0, 0);
    add_edge(5, 7, 0);
    add_edge(0, 0, 1);
    drain(2);
    // Full damping, self link, duplicates, outside edges, widest threshold
    set_all(3, 65535, 32'hFFFF_FFFF, 255);
    add_edge(0, 1, 0);
    add_edge(0, 1, 0);
    add_edge(1, 1, 0);
    add_edge(2, 0, 0);
    add_edge(63, 63, 0);
    add_edge(1, 2, 1);
    drain(3);
    // Node count above range clamps to 64
    set_all(127, 55706, 32'd0, 2);
    add_ring();
    drain(0);
    // Final edge outside the graph: every node dangling
    set_all(2, 1, 32'd1000, 4);
    add_edge(40, 3, 1);
    drain(1);

    // Random solves on small graphs
    phase = 2;
    while (edges_sent < 330) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      pick = $urandom_range(0, 3);
      thr = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom_range(0, 4000)
          : (pick == 2) ? $urandom : 32'hFFFF_FFFF;
      lim = (thr == 32'hFFFF_FFFF && $urandom_range(0, 1)) ? 255 : $urandom_range(0, 8);
      set_all(n, ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 65535), thr, lim);
      cnt = $urandom_range(1, 12);
      for (int k = 0; k < cnt; k++) begin
        if ($urandom_range(0, 9) == 0) add_edge($urandom_range(0, 63), $urandom_range(0, 63), 0);
        else add_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), 0);
      end
      add_edge($urandom_range(0, 63), $urandom_range(0, 63), 1);
      drain(phase);
      phase++;
    end
    repeat (50) @(posedge clk);

    $display("%0d edge beats, %0d solves, %0d rank beats checked, %0d mismatches",
             edges_sent, solves, ranks_seen, mismatches);
    if (mismatches == 0 && rank_queue.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end
endmodule
